FILE: rtl/core/marlf_pkg.sv
`timescale 1ns / 1ps
package marlf_pkg;
	localparam int SAMPLE_W = 32;
	localparam int SUM_W    = 48;
	// Divider numerator: |dy| plus half the index step.
	localparam int NUM_W    = 34;
	// Signed slope, Q34.0 plus sign.
	localparam int SLOPE_W  = 35;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
endpackage

FILE: rtl/core/marlf_ram.sv
`timescale 1ns / 1ps
module marlf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/marlf_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, MSB first.
module marlf_div #(
	parameter int DEN_W = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [marlf_pkg::NUM_W-1:0] num,
	input  logic [DEN_W-1:0]           den,
	output logic                       done,
	output logic [marlf_pkg::NUM_W-1:0] quot
);
	localparam int CW = $clog2(marlf_pkg::NUM_W + 1);

	logic [CW-1:0]                cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [DEN_W:0]               rem_q;
	logic [marlf_pkg::NUM_W-1:0]  quo_q;
	logic [DEN_W:0]               rem_sh;
	logic                         ge;

	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[marlf_pkg::NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(marlf_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
			quo_q <= {quo_q[marlf_pkg::NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule

FILE: rtl/core/min_abs_residual_line_fit_core.sv
`timescale 1ns / 1ps
// Points load at one item per cycle unless a held result is stalled at the output;
// a non-last item leaves no result. After the last item the pair search runs: per
// pair a setup (two store reads, serial slope divider, multiply, base), then the
// residual sum and one compare. Input stalls during the search, so a new set of
// points is taken only once the search is done.
// Reset clears the point count, best sum (to all ones) and handshake state; the
// point store is not cleared, only entries written in the current run are read.
module min_abs_residual_line_fit_core #(
	parameter int MAX_POINTS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [marlf_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                            last_point,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [marlf_pkg::SUM_W-1:0]     min_residual_sum,
	output logic                            too_few_points
);
	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int MUL_W = marlf_pkg::SLOPE_W + IDX_W + 1;
	// Line value and residual width: slope times index plus headroom.
	localparam int LW    = marlf_pkg::SLOPE_W + IDX_W + 3;
	localparam int ACC_W = ((LW > marlf_pkg::SUM_W) ? LW : marlf_pkg::SUM_W) + 1;
	localparam int SW    = marlf_pkg::SAMPLE_W;

	typedef enum logic [3:0] {
		ST_LOAD, ST_RD_I, ST_RD_J, ST_DIV_GO, ST_DIV_WAIT,
		ST_MUL, ST_BASE, ST_SUM, ST_CMP, ST_DONE
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              n_q;
	logic [IDX_W-1:0]              i_q, j_q;
	logic [CNT_W-1:0]              t_q;
	logic                          v_s1, v_s2;
	logic [marlf_pkg::SUM_W-1:0]   best_q;
	logic [marlf_pkg::SUM_W-1:0]   sum_q;
	logic                          out_valid_q;
	logic [marlf_pkg::SUM_W-1:0]   out_sum_q;
	logic                          out_few_q;

	// Datapath registers, no reset needed.
	logic signed [SW-1:0]                yi_q;
	logic                                neg_q;
	logic signed [marlf_pkg::SLOPE_W-1:0] m_q;
	logic signed [MUL_W-1:0]             mi_q;
	logic signed [LW-1:0]                line_q;
	logic [LW-1:0]                       abs_s2;

	logic                          accept, out_take, store_ok;
	logic [CNT_W-1:0]              n_next;
	logic [IDX_W-1:0]              raddr;
	logic [SW-1:0]                 rdata;
	logic signed [SW:0]            dy;
	logic [SW:0]                   dy_mag;
	logic [marlf_pkg::NUM_W-1:0]   div_num;
	logic [IDX_W-1:0]              dx;
	logic                          div_start, div_done;
	logic [marlf_pkg::NUM_W-1:0]   div_quot;
	logic signed [LW-1:0]          resid;
	logic [ACC_W-1:0]              acc_next;

	// Input handshake: take points only while loading and while a result
	// that may be created here has room in the output register.
	assign out_take = out_valid_q && !out_stall;
	assign in_stall = (state_q != ST_LOAD) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign store_ok = n_q < CNT_W'(MAX_POINTS);
	assign n_next   = store_ok ? n_q + 1'b1 : n_q;

	// Store read address follows the sequencer.
	always_comb begin
		case (state_q)
			ST_RD_I: raddr = i_q;
			ST_RD_J: raddr = j_q;
			ST_SUM:  raddr = t_q[IDX_W-1:0];
			default: raddr = '0;
		endcase
	end

	marlf_ram #(.WIDTH(SW), .DEPTH(MAX_POINTS)) u_store (
		.clk   (clk),
		.we    (accept && store_ok),
		.waddr (n_q[IDX_W-1:0]),
		.wdata (sample_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Slope: |dy| / dx rounded half away from zero, sign restored afterward.
	assign dy        = $signed({rdata[SW-1], rdata}) - $signed({yi_q[SW-1], yi_q});
	assign dy_mag    = dy[SW] ? (SW+1)'(0) - dy : dy;
	assign dx        = j_q - i_q;
	assign div_num   = marlf_pkg::NUM_W'(dy_mag) + marlf_pkg::NUM_W'(dx >> 1);
	assign div_start = (state_q == ST_DIV_GO);

	marlf_div #(.DEN_W(IDX_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (dx),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Residual of the point read last cycle against the running line value.
	assign resid    = LW'($signed(rdata)) - line_q;
	assign acc_next = ACC_W'(sum_q) + ACC_W'(abs_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			t_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			best_q      <= marlf_pkg::SUM_MAX;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			out_sum_q   <= '0;
			out_few_q   <= 1'b0;
		end else begin
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						n_q <= n_next;
						if (last_point) begin
							if (n_next < CNT_W'(2)) begin
								// Too few points: flag, zero sum, start over.
								out_valid_q <= 1'b1;
								out_sum_q   <= '0;
								out_few_q   <= 1'b1;
								n_q         <= '0;
							end else begin
								i_q     <= '0;
								j_q     <= IDX_W'(1);
								state_q <= ST_RD_I;
							end
						end
					end
				end
				ST_RD_I:     state_q <= ST_RD_J;
				ST_RD_J:     state_q <= ST_DIV_GO;
				ST_DIV_GO:   state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:      state_q <= ST_BASE;
				ST_BASE: begin
					t_q     <= '0;
					v_s1    <= 1'b0;
					v_s2    <= 1'b0;
					sum_q   <= '0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					// Issue reads, one point per cycle, then drain the pipe.
					if (t_q != n_q) begin
						t_q  <= t_q + 1'b1;
						v_s1 <= 1'b1;
					end else begin
						v_s1 <= 1'b0;
					end
					v_s2 <= v_s1;
					if (v_s2) begin
						sum_q <= (acc_next > ACC_W'(marlf_pkg::SUM_MAX)) ?
							marlf_pkg::SUM_MAX : acc_next[marlf_pkg::SUM_W-1:0];
					end
					if (t_q == n_q && !v_s1 && !v_s2) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (sum_q < best_q) begin
						best_q <= sum_q;
					end
					// Advance to the next pair (i < j).
					if (CNT_W'(j_q) + 1'b1 < n_q) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_RD_I;
					end else if (CNT_W'(i_q) + CNT_W'(2) < n_q) begin
						i_q     <= i_q + 1'b1;
						j_q     <= i_q + IDX_W'(2);
						state_q <= ST_RD_I;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold until the output register is free.
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_sum_q   <= best_q;
						out_few_q   <= 1'b0;
						best_q      <= marlf_pkg::SUM_MAX;
						n_q         <= '0;
						state_q     <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD_J) begin
			yi_q <= $signed(rdata);
		end
		if (state_q == ST_DIV_GO) begin
			neg_q <= dy[SW];
		end
		if (state_q == ST_DIV_WAIT && div_done) begin
			m_q <= neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
		end
		if (state_q == ST_MUL) begin
			mi_q <= MUL_W'(m_q * $signed({1'b0, i_q}));
		end
		if (state_q == ST_BASE) begin
			line_q <= LW'(yi_q) - LW'(mi_q);
		end else if (state_q == ST_SUM && v_s1) begin
			// Step the line value by the slope for the next index.
			line_q <= line_q + LW'(m_q);
			abs_s2 <= resid[LW-1] ? LW'(0) - resid : resid;
		end
	end

	assign out_valid        = out_valid_q;
	assign min_residual_sum = out_sum_q;
	assign too_few_points   = out_few_q;

	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_few_points |-> min_residual_sum == '0)
		else $error("too-few result carries a nonzero sum");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_POINTS))
		else $error("point count past capacity");

	a_pipe_in_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> state_q == ST_SUM)
		else $error("residual pipe busy outside sum phase");

	a_div_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_WAIT && div_done) |=> state_q == ST_MUL)
		else $error("slope not taken after divide");

	a_search_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM |-> n_q >= CNT_W'(2) && t_q <= n_q)
		else $error("sum phase with bad point index");
endmodule
